// ===== rtl/i2cm_pkg.sv =====
// Package with the shared types, codes and sizes of the I2C master transfer sequencer.
package i2cm_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [7:0] ST_CODE_MASK = 8'hF8;
	localparam logic [7:0] ST_START_DONE = 8'h08;
	localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
	localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	typedef enum logic [1:0] {
		OP_START_WRITE = 2'd0,
		OP_START_READ  = 2'd1,
		OP_LOAD        = 2'd2,
		OP_BUS_EVENT   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_SEND    = 3'd2,
		CMD_RX_ACK  = 3'd3,
		CMD_RX_NACK = 3'd4,
		CMD_STOP    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		XS_BUSY = 2'd0,
		XS_OK   = 2'd1,
		XS_FAIL = 2'd2
	} xfer_status_t;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_WAIT_START = 3'd1,
		PH_WAIT_ADDR  = 3'd2,
		PH_WAIT_DATA  = 3'd3
	} phase_t;

	localparam logic CFG_TARGET_ADDRESS = 1'b0;
	localparam logic CFG_MAX_ATTEMPTS = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [5:0] length;
		logic [4:0] load_index;
		logic [7:0] write_byte;
		logic [7:0] bus_status;
		logic [7:0] bus_data;
	} item_t;

	typedef struct packed {
		logic [2:0] bus_command;
		logic [7:0] bus_byte;
		logic       read_valid;
		logic [4:0] read_index;
		logic [7:0] rx_byte;
		logic [1:0] transfer_status;
		logic       last_of_run;
	} result_t;

	// Results of one item, waiting in a register for the buffer read.
	typedef struct packed {
		logic [1:0] count;
		logic       use_ram;
		result_t    res0;
		result_t    res1;
	} stage_t;

	// Results handed to the output queue together.
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage

// ===== rtl/i2c_master_transfer_retry.sv =====
// Top level of the I2C master transfer sequencer with retry.
//
// The item channel (item_valid, item_stall, item) carries one word per command:
// start write, start read, load of a write buffer byte, or a bus event from the
// byte-level engine with its status code and received byte. The result channel
// (result_valid, result_stall, result) returns the bus commands to issue, with
// any received byte and the transfer status. An item causes zero, one or two
// result words; the last word of an item has last_of_run set.
//
// An accepted item is decoded as it is accepted: the phase, position and retry
// registers update and the write buffer RAM is read. The item's words wait in
// a stage register for the registered buffer byte, which is then merged, and
// are pushed into a four-word output queue; result_valid is set while the queue
// holds a word. Items can be accepted back to back, one per clock, while
// the queued and in-flight words leave room for two more.
// Reset clears the phase, retry count and queue and restores address 0 and five
// attempts; the write buffer is not cleared. A stalled receiver holds the head
// word, and item_stall rises once the queue cannot take two more words.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
module i2c_master_transfer_retry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  i2cm_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output i2cm_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [6:0]         cfg_data
);
	import i2cm_pkg::*;

	logic              accept;
	logic              ram_we;
	logic [BUF_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	stage_t            stage_s1;
	push_t             push;
	logic [2:0]        q_count;
	logic [3:0]        occupancy;

	// Words already queued plus those of the item still waiting on the buffer read.
	assign occupancy = {1'b0, q_count} + {2'b00, stage_s1.count};
	assign item_stall = occupancy > 4'(OUTQ_DEPTH - 2);
	assign accept = item_valid && !item_stall;
	assign result_valid = q_count != 3'd0;

	i2cm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.stage_s1  (stage_s1)
	);

	i2cm_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_txbuf (
		.clk   (clk),
		.we    (ram_we && accept),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The data byte to send comes straight from the buffer read.
	always_comb begin
		push.count = stage_s1.count;
		push.res0 = stage_s1.res0;
		push.res1 = stage_s1.res1;
		if (stage_s1.use_ram) begin
			push.res0.bus_byte = ram_rdata;
		end
	end

	i2cm_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (result_valid && !result_stall),
		.count  (q_count),
		.head   (result)
	);

endmodule

// ===== rtl/i2cm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module i2cm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/i2cm_seq.sv =====
// Transfer sequencer: phase state machine, retry counting and result forming.
module i2cm_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  i2cm_pkg::item_t              item,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [6:0]                   cfg_data,
	output logic                         ram_we,
	output logic [i2cm_pkg::BUF_AW-1:0]  ram_waddr,
	output logic [7:0]                   ram_wdata,
	output logic [i2cm_pkg::BUF_AW-1:0]  ram_raddr,
	output i2cm_pkg::stage_t             stage_s1
);
	import i2cm_pkg::*;

	phase_t     phase_q, phase_d;
	logic       is_read_q, is_read_d;
	logic [4:0] pos_q, pos_d;
	logic [5:0] len_q, len_d;
	logic [3:0] att_q, att_d;
	logic [6:0] target_q;
	logic [3:0] max_att_q;
	stage_t     stage_d;

	logic [7:0] status;
	logic [5:0] pos_p1, pos_p2, len_clamped;
	logic [3:0] att_inc;
	logic       fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			is_read_q <= 1'b0;
			pos_q <= '0;
			len_q <= '0;
			att_q <= '0;
			target_q <= '0;
			max_att_q <= 4'd5;
			stage_s1 <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				is_read_q <= is_read_d;
				pos_q <= pos_d;
				len_q <= len_d;
				att_q <= att_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET_ADDRESS: target_q <= cfg_data;
					CFG_MAX_ATTEMPTS:   max_att_q <= cfg_data[3:0];
					default:            ;
				endcase
			end
			stage_s1.count <= accept ? stage_d.count : 2'd0;
			stage_s1.use_ram <= stage_d.use_ram;
			stage_s1.res0 <= stage_d.res0;
			stage_s1.res1 <= stage_d.res1;
		end
	end

	always_comb begin
		status = item.bus_status & ST_CODE_MASK;
		pos_p1 = {1'b0, pos_q} + 6'd1;
		pos_p2 = {1'b0, pos_q} + 6'd2;
		att_inc = att_q + 4'd1;
		if (item.length == 6'd0) begin
			len_clamped = 6'd1;
		end else if ({3'b000, item.length} > 9'(BUF_DEPTH)) begin
			len_clamped = 6'(BUF_DEPTH);
		end else begin
			len_clamped = item.length;
		end

		phase_d = phase_q;
		is_read_d = is_read_q;
		pos_d = pos_q;
		len_d = len_q;
		att_d = att_q;
		stage_d = '0;
		ram_we = 1'b0;
		ram_waddr = BUF_AW'(item.load_index);
		ram_wdata = item.write_byte;
		ram_raddr = BUF_AW'(pos_q);
		fail = 1'b0;

		case (op_t'(item.operation))
			OP_START_WRITE, OP_START_READ: begin
				len_d = len_clamped;
				is_read_d = item.operation[0];
				pos_d = '0;
				att_d = '0;
				phase_d = PH_WAIT_START;
				stage_d.count = 2'd1;
				stage_d.res0.bus_command = CMD_START;
				stage_d.res0.last_of_run = 1'b1;
			end
			OP_LOAD: begin
				ram_we = ({3'b000, item.load_index} < 8'(BUF_DEPTH));
			end
			default: begin
				case (phase_q)
					PH_WAIT_START: begin
						if (status != ST_START_DONE) begin
							fail = 1'b1;
						end else begin
							phase_d = PH_WAIT_ADDR;
							stage_d.count = 2'd1;
							stage_d.res0.bus_command = CMD_SEND;
							stage_d.res0.bus_byte = {target_q, is_read_q};
							stage_d.res0.last_of_run = 1'b1;
						end
					end
					PH_WAIT_ADDR: begin
						if (status != (is_read_q ? ST_ADDR_R_ACK : ST_ADDR_W_ACK)) begin
							fail = 1'b1;
						end else begin
							phase_d = PH_WAIT_DATA;
							stage_d.count = 2'd1;
							stage_d.res0.last_of_run = 1'b1;
							if (is_read_q) begin
								stage_d.res0.bus_command =
									(pos_p1 >= len_q) ? CMD_RX_NACK : CMD_RX_ACK;
							end else begin
								stage_d.res0.bus_command = CMD_SEND;
								stage_d.use_ram = 1'b1;
								ram_raddr = BUF_AW'(pos_q);
							end
						end
					end
					PH_WAIT_DATA: begin
						if (is_read_q) begin
							if (status != ((pos_p1 >= len_q) ? ST_DATA_R_NACK
									: ST_DATA_R_ACK)) begin
								fail = 1'b1;
							end else begin
								stage_d.count = 2'd1;
								stage_d.res0.read_valid = 1'b1;
								stage_d.res0.read_index = pos_q;
								stage_d.res0.rx_byte = item.bus_data;
								stage_d.res0.last_of_run = 1'b1;
								if (pos_p1 >= len_q) begin
									phase_d = PH_IDLE;
									stage_d.res0.bus_command = CMD_STOP;
									stage_d.res0.transfer_status = XS_OK;
								end else begin
									pos_d = pos_p1[4:0];
									stage_d.res0.bus_command =
										(pos_p2 >= len_q) ? CMD_RX_NACK : CMD_RX_ACK;
								end
							end
						end else begin
							if (status != ST_DATA_W_ACK) begin
								fail = 1'b1;
							end else begin
								pos_d = pos_p1[4:0];
								stage_d.count = 2'd1;
								stage_d.res0.last_of_run = 1'b1;
								if (pos_p1 >= len_q) begin
									phase_d = PH_IDLE;
									stage_d.res0.bus_command = CMD_STOP;
									stage_d.res0.transfer_status = XS_OK;
								end else begin
									stage_d.res0.bus_command = CMD_SEND;
									stage_d.use_ram = 1'b1;
									ram_raddr = BUF_AW'(pos_p1);
								end
							end
						end
					end
					default: ;
				endcase
			end
		endcase

		if (fail) begin
			pos_d = '0;
			att_d = att_inc;
			stage_d.res0.bus_command = CMD_STOP;
			if (att_inc >= max_att_q) begin
				phase_d = PH_IDLE;
				stage_d.count = 2'd1;
				stage_d.res0.transfer_status = XS_FAIL;
				stage_d.res0.last_of_run = 1'b1;
			end else begin
				phase_d = PH_WAIT_START;
				stage_d.count = 2'd2;
				stage_d.res1.bus_command = CMD_START;
				stage_d.res1.last_of_run = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/i2cm_outq.sv =====
// Output queue: up to two result words pushed and one popped per cycle.
module i2cm_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  i2cm_pkg::push_t    push,
	input  logic               pop,
	output logic [2:0]         count,
	output i2cm_pkg::result_t  head
);
	import i2cm_pkg::*;

	localparam int PW = $clog2(OUTQ_DEPTH);

	result_t       entry_q [OUTQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [2:0]    count_q;

	assign wr_ptr_p1 = wr_ptr_q + PW'(1);
	assign count = count_q;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.res1;
		end
	end

endmodule

// ===== rtl/i2cm_checker.sv =====
// Port-level checker for the I2C master transfer sequencer, bound to the top level.
module i2cm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input i2cm_pkg::item_t    item,
	input logic               result_valid,
	input logic               result_stall,
	input i2cm_pkg::result_t  result,
	input logic               cfg_we,
	input logic               cfg_index,
	input logic [6:0]         cfg_data
);
	import i2cm_pkg::*;

	// A stalled result word holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// An abort always ends the run with a stop.
	a_fail_stop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.transfer_status == XS_FAIL |->
			result.bus_command == CMD_STOP && result.last_of_run)
		else $error("abort without final stop");

	// A delivered read byte goes with a receive command or the closing stop.
	a_read_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.read_valid |->
			result.bus_command == CMD_RX_ACK || result.bus_command == CMD_RX_NACK ||
			result.bus_command == CMD_STOP)
		else $error("read byte delivered with wrong command");

	// Nothing is left in the output after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid right after reset");

endmodule

bind i2c_master_transfer_retry i2cm_checker u_i2cm_checker (.*);

// ===== verif/tb_i2c_master_transfer_retry.sv =====
// Self-checking testbench for the I2C master transfer sequencer with retry.
module tb_i2c_master_transfer_retry;
	import i2cm_pkg::*;

	// Scoreboard: a cycle-free model of the sequencer. Every accepted item word
	// is run through it, and the result words it produces wait in order until
	// the block delivers the matching words.
	class xfer_scoreboard;
		logic [6:0]  dev_addr;
		logic [3:0]  attempt_limit;
		phase_t      phase;
		logic        reading;
		int unsigned pos;
		int unsigned xfer_len;
		logic [3:0]  fails;
		logic [7:0]  tx_mem [BUF_DEPTH];
		bit          tx_loaded [BUF_DEPTH];
		result_t     due_q [$];
		int          errors, checked, starts, retries, aborts, rx_bytes;

		function new();
			dev_addr = 7'd0;
			attempt_limit = 4'd5;
			phase = PH_IDLE;
			reading = 1'b0;
			pos = 0;
			xfer_len = 0;
			fails = 4'd0;
			foreach (tx_loaded[i]) tx_loaded[i] = 1'b0;
		endfunction

		function void configure(logic idx, logic [6:0] value);
			if (idx == CFG_TARGET_ADDRESS)
				dev_addr = value;
			else
				attempt_limit = value[3:0];
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		// Status code the bus engine must report in the current phase.
		function logic [7:0] status_due();
			case (phase)
			PH_WAIT_START: return ST_START_DONE;
			PH_WAIT_ADDR:  return reading ? ST_ADDR_R_ACK : ST_ADDR_W_ACK;
			default: begin
				if (!reading)
					return ST_DATA_W_ACK;
				return (pos + 1 >= xfer_len) ? ST_DATA_R_NACK : ST_DATA_R_ACK;
			end
			endcase
		endfunction

		function void emit(cmd_t cmd, logic [7:0] b, logic rv, logic [4:0] ri,
				logic [7:0] rb, xfer_status_t st, logic last);
			result_t r;
			r.bus_command = cmd;
			r.bus_byte = b;
			r.read_valid = rv;
			r.read_index = ri;
			r.rx_byte = rb;
			r.transfer_status = st;
			r.last_of_run = last;
			due_q.push_back(r);
		endfunction

		// Command that begins the byte at the current position.
		function void emit_next(logic rv, logic [4:0] ri, logic [7:0] rb);
			if (reading)
				emit((pos + 1 >= xfer_len) ? CMD_RX_NACK : CMD_RX_ACK, 8'd0, rv, ri, rb,
					XS_BUSY, 1'b1);
			else
				emit(CMD_SEND, tx_mem[pos], rv, ri, rb, XS_BUSY, 1'b1);
		endfunction

		function void fail_attempt();
			pos = 0;
			fails = fails + 4'd1;
			if (fails >= attempt_limit) begin
				phase = PH_IDLE;
				aborts++;
				emit(CMD_STOP, 8'd0, 1'b0, 5'd0, 8'd0, XS_FAIL, 1'b1);
			end else begin
				phase = PH_WAIT_START;
				retries++;
				emit(CMD_STOP, 8'd0, 1'b0, 5'd0, 8'd0, XS_BUSY, 1'b0);
				emit(CMD_START, 8'd0, 1'b0, 5'd0, 8'd0, XS_BUSY, 1'b1);
			end
		endfunction

		function void note_item(item_t w);
			logic [7:0]  st;
			int unsigned len;
			logic [4:0]  here;
			st = w.bus_status & ST_CODE_MASK;
			case (op_t'(w.operation))
			OP_START_WRITE, OP_START_READ: begin
				len = w.length;
				if (len < 1) len = 1;
				if (len > BUF_DEPTH) len = BUF_DEPTH;
				xfer_len = len;
				reading = (w.operation == OP_START_READ);
				pos = 0;
				fails = 4'd0;
				phase = PH_WAIT_START;
				starts++;
				emit(CMD_START, 8'd0, 1'b0, 5'd0, 8'd0, XS_BUSY, 1'b1);
			end
			OP_LOAD: begin
				tx_mem[w.load_index] = w.write_byte;
				tx_loaded[w.load_index] = 1'b1;
			end
			default: begin
				if (phase == PH_IDLE)
					return;
				if (st != status_due()) begin
					fail_attempt();
					return;
				end
				case (phase)
				PH_WAIT_START: begin
					phase = PH_WAIT_ADDR;
					emit(CMD_SEND, {dev_addr, reading}, 1'b0, 5'd0, 8'd0, XS_BUSY, 1'b1);
				end
				PH_WAIT_ADDR: begin
					phase = PH_WAIT_DATA;
					emit_next(1'b0, 5'd0, 8'd0);
				end
				default: begin
					if (reading) begin
						here = pos[4:0];
						rx_bytes++;
						if (pos + 1 >= xfer_len) begin
							phase = PH_IDLE;
							emit(CMD_STOP, 8'd0, 1'b1, here, w.bus_data, XS_OK, 1'b1);
						end else begin
							pos++;
							emit_next(1'b1, here, w.bus_data);
						end
					end else begin
						pos++;
						if (pos >= xfer_len) begin
							phase = PH_IDLE;
							emit(CMD_STOP, 8'd0, 1'b0, 5'd0, 8'd0, XS_OK, 1'b1);
						end else begin
							emit_next(1'b0, 5'd0, 8'd0);
						end
					end
				end
				endcase
			end
			endcase
		endfunction

		function bit differs(string field, logic [7:0] want, logic [7:0] got);
			if (got === want)
				return 1'b0;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			return 1'b1;
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit bad;
			checked++;
			if (due_q.size() == 0) begin
				$display("%0t: result word %0h expected none, got one", $time, got);
				errors++;
				return;
			end
			want = due_q.pop_front();
			bad = differs("bus_command", want.bus_command, got.bus_command);
			bad |= differs("bus_byte", want.bus_byte, got.bus_byte);
			bad |= differs("read_valid", want.read_valid, got.read_valid);
			bad |= differs("read_index", want.read_index, got.read_index);
			bad |= differs("rx_byte", want.rx_byte, got.rx_byte);
			bad |= differs("transfer_status", want.transfer_status, got.transfer_status);
			bad |= differs("last_of_run", want.last_of_run, got.last_of_run);
			if (bad)
				errors++;
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      item = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [6:0] cfg_data = 7'd0;

	// When set, neither side inserts idle cycles. Updated with a nonblocking
	// assignment so both sides see the same value.
	logic quiet = 1'b0;
	int   stim_count = 0;
	int   stall_left = 0;

	xfer_scoreboard sb;

	i2c_master_transfer_retry u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// A hard stop well past the slowest correct run.
	initial begin
		#2000000;
		$display("%0t: run timed out", $time);
		$display("i2c_master_transfer_retry: mismatch");
		$finish;
	end

	// The receiver stalls in random bursts of random length; no new burst begins
	// while quiet is set.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Every result word accepted at an edge is compared with the oldest
	// expectation. Signals are read before the edge's updates land.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	function automatic item_t random_item();
		item_t w;
		w.operation = 2'($urandom_range(0, 3));
		w.length = 6'($urandom_range(0, 63));
		w.load_index = 5'($urandom_range(0, 31));
		w.write_byte = 8'($urandom_range(0, 255));
		w.bus_status = 8'($urandom_range(0, 255));
		w.bus_data = 8'($urandom_range(0, 255));
		return w;
	endfunction

	// Mostly short transfers, with the full buffer and out-of-range lengths
	// now and then so that the clamping is exercised.
	function automatic logic [5:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 6'($urandom_range(1, 6));
		if (r < 85) return 6'($urandom_range(7, 31));
		if (r < 93) return 6'(BUF_DEPTH);
		if (r < 97) return 6'($urandom_range(33, 63));
		return 6'd0;
	endfunction

	// Presents one word and holds it until it is accepted, then hands it to the
	// scoreboard. Valid stays high into the next word unless a gap is drawn.
	task automatic send_item(input item_t w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		sb.note_item(w);
	endtask

	task automatic load_byte(input logic [4:0] idx, input logic [7:0] value);
		item_t w;
		w = random_item();
		w.operation = OP_LOAD;
		w.load_index = idx;
		w.write_byte = value;
		send_item(w);
	endtask

	task automatic bus_event(input logic [7:0] status);
		item_t w;
		w = random_item();
		w.operation = OP_BUS_EVENT;
		w.bus_status = status;
		send_item(w);
	endtask

	// A write must never send a buffer entry that was never loaded, so any
	// missing entry within the clamped length is loaded first.
	task automatic start_xfer(input op_t op, input logic [5:0] len);
		item_t w;
		int unsigned span;
		span = (len == 0) ? 1 : ((len > BUF_DEPTH) ? BUF_DEPTH : len);
		if (op == OP_START_WRITE)
			for (int i = 0; i < span; i++)
				if (!sb.tx_loaded[i])
					load_byte(5'(i), 8'($urandom_range(0, 255)));
		w = random_item();
		w.operation = op;
		w.length = len;
		send_item(w);
	endtask

	// One random step. Most steps carry the status the sequencer waits for,
	// with random don't-care bits, so transfers run to their end; the rest are
	// wrong statuses, loads, starts that cut a transfer short, and stray events.
	task automatic random_step();
		int r;
		logic [7:0] code;
		logic [7:0] s;
		r = $urandom_range(0, 99);
		if (sb.phase == PH_IDLE) begin
			if (r < 6) begin
				// Ignored by the block, so it does not count.
				bus_event(8'($urandom_range(0, 255)));
				return;
			end
			if (r < 16)
				load_byte(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
			else
				start_xfer($urandom_range(0, 1) ? OP_START_READ : OP_START_WRITE,
					pick_length());
		end else if (r < 4) begin
			load_byte(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
		end else if (r < 6) begin
			start_xfer($urandom_range(0, 1) ? OP_START_READ : OP_START_WRITE, pick_length());
		end else begin
			code = sb.status_due();
			if (r < 11) begin
				do s = 8'($urandom_range(0, 255)); while ((s & ST_CODE_MASK) == code);
			end else begin
				s = code | 8'($urandom_range(0, 7));
			end
			bus_event(s);
		end
		stim_count++;
	endtask

	// Idles the item channel and lets every expected word arrive, so that a load
	// still in the pipeline has landed before the registers change.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.configure(idx, value);
	endtask

	initial begin
		logic [6:0] addr;
		logic [3:0] limit;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, at the reset register values. A bus event with no
		// transfer running is ignored, then the ends of the write buffer are
		// loaded.
		bus_event(8'hFF);
		load_byte(5'd0, 8'hFF);
		load_byte(5'd31, 8'h00);

		// A zero length is taken as one byte; don't-care status bits are set.
		start_xfer(OP_START_WRITE, 6'd0);
		bus_event(ST_START_DONE);
		bus_event(ST_ADDR_W_ACK | 8'h07);
		bus_event(ST_DATA_W_ACK);

		// An oversized read is cut short by a new start, which abandons it
		// without a stop. The write then sees a wrong status on its address
		// byte, so it stops, restarts and completes.
		start_xfer(OP_START_READ, 6'd63);
		bus_event(ST_START_DONE | 8'h07);
		start_xfer(OP_START_WRITE, 6'd1);
		bus_event(ST_START_DONE);
		bus_event(ST_DATA_W_ACK);
		bus_event(ST_START_DONE);
		bus_event(ST_ADDR_W_ACK);
		bus_event(ST_DATA_W_ACK);

		// A two-byte read whose last byte arrives with ack instead of nack.
		// The retry delivers the first byte again at the same position.
		start_xfer(OP_START_READ, 6'd2);
		bus_event(ST_START_DONE);
		bus_event(ST_ADDR_R_ACK);
		bus_event(ST_DATA_R_ACK);
		bus_event(ST_DATA_R_ACK);
		bus_event(ST_START_DONE);
		bus_event(ST_ADDR_R_ACK);
		bus_event(ST_DATA_R_ACK);
		bus_event(ST_DATA_R_NACK);

		// Random part in six register settings. A limit of zero or one makes
		// the first failure abort; both address extremes appear.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0: begin addr = 7'd0;   limit = 4'd0;  end
			1: begin addr = 7'h55;  limit = 4'd1;  end
			2: begin addr = 7'h2A;  limit = 4'd3;  end
			5: begin addr = 7'h7F;  limit = 4'd15; end
			default: begin
				addr = 7'($urandom_range(0, 127));
				limit = 4'($urandom_range(0, 15));
			end
			endcase
			drain();
			write_reg(CFG_TARGET_ADDRESS, addr);
			write_reg(CFG_MAX_ATTEMPTS, {3'd0, limit});
			cfg_we <= 1'b0;
			while (stim_count < (ph + 1) * 1850 / 6) begin
				// Every sixth stretch of 150 steps runs without idling, and
				// the tail of the run has none at all.
				quiet <= (stim_count >= 1600) || ((stim_count / 150) % 6 == 5);
				random_step();
			end
		end

		drain();
		repeat (12) @(posedge clk);
		$display("Covered %0d transfers with %0d retries and %0d aborts; %0d bytes read.",
			sb.starts, sb.retries, sb.aborts, sb.rx_bytes);
		$display("Checked %0d result words; %0d were wrong or unexpected.",
			sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("i2c_master_transfer_retry: match");
		else
			$display("i2c_master_transfer_retry: mismatch");
		$finish;
	end

endmodule
